// ===== rtl/clock_offset_tracker_beat_dedup_core_defines.svh =====
// assertion macros shared by the clock offset tracker rtl
`ifndef CLOCK_OFFSET_TRACKER_BEAT_DEDUP_CORE_DEFINES_SVH
`define CLOCK_OFFSET_TRACKER_BEAT_DEDUP_CORE_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, checked out of reset
`define COTBD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication, checked out of reset
`define COTBD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define COTBD_ASSERT_NOW(label, clk, rstn, ante, cons)
`define COTBD_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/cotbd_pkg.sv =====
// types and constants of the clock offset tracker
`timescale 1ns / 1ps

package cotbd_pkg;

    // weight of one in q1.16
    localparam logic [16:0] ALPHA_ONE = 17'h10000;
    // saturation value of the sample count
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // register reset values
    localparam logic [16:0] EMA_ALPHA_RST     = 17'd13107;
    localparam logic [16:0] EMA_ALPHA_DUP_RST = 17'd3277;
    localparam logic [7:0]  MIN_SAMPLES_RST   = 8'd4;
    localparam logic [15:0] SNAP_THR_RST      = 16'd1000;

    // register indexes of the configuration port
    localparam logic [7:0] CFG_EMA_ALPHA     = 8'd0;
    localparam logic [7:0] CFG_EMA_ALPHA_DUP = 8'd1;
    localparam logic [7:0] CFG_MIN_SAMPLES   = 8'd2;
    localparam logic [7:0] CFG_SNAP_THR      = 8'd3;

    // message kinds
    localparam logic OP_CONTROL = 1'b0;
    localparam logic OP_BEAT    = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [31:0] master_time_ms;
        logic [31:0] local_time_ms;
        logic [15:0] beat_number;
        logic [31:0] play_at_ms;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] offset_ms;
        logic               converged;
        logic               snapped;
        logic               duplicate;
        logic               performer_restart;
        logic               pending_valid;
        logic [15:0]        pending_beat_number;
        logic [31:0]        pending_play_ms;
        logic [31:0]        pending_queued_ms;
        logic [31:0]        last_beat_local_ms;
    } out_item_t;

    // result of the offset unit
    typedef struct packed {
        logic signed [31:0] offset;
        logic               snap;
    } offset_upd_t;

endpackage

// ===== rtl/cotbd_offset_unit.sv =====
// offset update: sample, snap test and q1.16 moving average
`timescale 1ns / 1ps

module cotbd_offset_unit (
    input  logic [31:0]          master_time_ms,
    input  logic [31:0]          local_time_ms,
    input  logic signed [31:0]   prev_offset,
    input  logic                 first_sample,
    input  logic [16:0]          alpha,
    input  logic [15:0]          snap_thr,
    output cotbd_pkg::offset_upd_t upd
);

    logic signed [31:0] sample;
    logic signed [32:0] jump;
    logic signed [32:0] thr_pos;
    logic signed [32:0] thr_neg;
    logic               over;
    logic [16:0]        alpha_eff;
    logic signed [17:0] alpha_s;
    logic signed [17:0] delta;
    logic signed [35:0] prod;
    logic signed [33:0] quot;
    logic               round_up;
    logic signed [33:0] ema;

    // sample and exact jump from the estimate
    assign sample  = signed'(master_time_ms - local_time_ms);
    assign jump    = {sample[31], sample} - {prev_offset[31], prev_offset};
    assign thr_pos = signed'({17'd0, snap_thr});
    assign thr_neg = -thr_pos;
    assign over    = (jump > thr_pos) || (jump < thr_neg);

    // weight limited to one
    assign alpha_eff = alpha[16] ? cotbd_pkg::ALPHA_ONE : alpha;
    assign alpha_s   = signed'({1'b0, alpha_eff});

    // without a snap the jump fits 17 bits signed
    assign delta = jump[17:0];
    assign prod  = alpha_s * delta;

    // prev + a*d/65536 truncated toward zero
    assign quot     = {{2{prev_offset[31]}}, prev_offset}
                      + {{14{prod[35]}}, prod[35:16]};
    assign round_up = quot[33] && (prod[15:0] != 16'd0);
    assign ema      = quot + {33'd0, round_up};

    // pick the new estimate
    always_comb begin
        upd.snap = 1'b0;
        if (first_sample) begin
            upd.offset = sample;
        end else if (over) begin
            upd.offset = sample;
            upd.snap   = 1'b1;
        end else begin
            upd.offset = ema[31:0];
        end
    end

endmodule

// ===== rtl/clock_offset_tracker_beat_dedup_core.sv =====
// top level of the clock offset tracker with beat de-duplication
//
//  channel | ports                                   | payload
//  --------+-----------------------------------------+----------------------
//  input   | s_valid, s_ready, s_data                | one received message
//  result  | m_valid, m_ready, m_data                | one result per message
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | register writes
//
// one message per cycle sustained while results are taken: input register,
// one pass of logic through the 17x18 weight multiply and the estimate add,
// then the result register, which holds the result until it is taken.
// reset is synchronous and active low; it clears all tracking state and
// loads the register defaults. config is always ready.
// a stalled result holds the result register; the input register still
// takes one message, then s_ready drops until the result is taken.
`timescale 1ns / 1ps
`include "clock_offset_tracker_beat_dedup_core_defines.svh"

module clock_offset_tracker_beat_dedup_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  cotbd_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output cotbd_pkg::out_item_t m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [7:0]           cfg_index,
    input  logic [31:0]          cfg_data
);

    // configuration registers
    logic [16:0] alpha_reg;
    logic [16:0] alpha_dup_reg;
    logic [7:0]  min_samples_reg;
    logic [15:0] snap_thr_reg;

    // pipeline registers
    logic                 in_vld_reg;
    cotbd_pkg::in_item_t  in_reg;
    logic                 out_vld_reg;
    cotbd_pkg::out_item_t out_reg;

    // tracking state
    logic signed [31:0] offset_reg,        offset_next;
    logic [15:0]        count_reg,         count_next;
    logic               conv_reg,          conv_next;
    logic               have_first_reg,    have_first_next;
    logic [15:0]        last_bn_reg,       last_bn_next;
    logic               pend_reg,          pend_next;
    logic [15:0]        pend_bn_reg,       pend_bn_next;
    logic [31:0]        pend_play_reg,     pend_play_next;
    logic [31:0]        pend_queued_reg,   pend_queued_next;
    logic [31:0]        last_beat_reg,     last_beat_next;

    logic                   advance;
    logic                   is_beat;
    logic                   dup_match;
    logic                   dup;
    logic [16:0]            alpha_sel;
    logic [15:0]            count_base;
    cotbd_pkg::offset_upd_t upd;
    cotbd_pkg::out_item_t   res;

    // handshakes
    assign advance   = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready   = !in_vld_reg || advance;
    assign m_valid   = out_vld_reg;
    assign m_data    = out_reg;
    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg       <= cotbd_pkg::EMA_ALPHA_RST;
            alpha_dup_reg   <= cotbd_pkg::EMA_ALPHA_DUP_RST;
            min_samples_reg <= cotbd_pkg::MIN_SAMPLES_RST;
            snap_thr_reg    <= cotbd_pkg::SNAP_THR_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                cotbd_pkg::CFG_EMA_ALPHA:     alpha_reg       <= cfg_data[16:0];
                cotbd_pkg::CFG_EMA_ALPHA_DUP: alpha_dup_reg   <= cfg_data[16:0];
                cotbd_pkg::CFG_MIN_SAMPLES:   min_samples_reg <= cfg_data[7:0];
                cotbd_pkg::CFG_SNAP_THR:      snap_thr_reg    <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_vld_reg <= 1'b1;
        end else if (advance) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    // duplicate check and weight choice
    assign is_beat   = (in_reg.operation == cotbd_pkg::OP_BEAT);
    assign dup_match = is_beat && have_first_reg && (in_reg.beat_number == last_bn_reg);
    assign alpha_sel = dup_match ? alpha_dup_reg : alpha_reg;

    cotbd_offset_unit u_offset (
        .master_time_ms (in_reg.master_time_ms),
        .local_time_ms  (in_reg.local_time_ms),
        .prev_offset    (offset_reg),
        .first_sample   (count_reg == 16'd0),
        .alpha          (alpha_sel),
        .snap_thr       (snap_thr_reg),
        .upd            (upd)
    );

    assign dup        = dup_match && !upd.snap;
    assign count_base = upd.snap ? 16'd0 : count_reg;

    // next tracking state
    always_comb begin
        offset_next      = upd.offset;
        count_next       = (count_base == cotbd_pkg::COUNT_MAX) ? count_base
                                                                : count_base + 16'd1;
        conv_next        = (conv_reg && !upd.snap)
                           || (count_next >= {8'd0, min_samples_reg});
        have_first_next  = have_first_reg && !upd.snap;
        last_bn_next     = upd.snap ? 16'd0 : last_bn_reg;
        pend_next        = pend_reg && !upd.snap;
        pend_bn_next     = pend_bn_reg;
        pend_play_next   = pend_play_reg;
        pend_queued_next = pend_queued_reg;
        last_beat_next   = last_beat_reg;
        if (is_beat) begin
            if (!dup) begin
                pend_next        = 1'b1;
                pend_bn_next     = in_reg.beat_number;
                pend_play_next   = in_reg.play_at_ms;
                pend_queued_next = in_reg.local_time_ms;
                last_bn_next     = in_reg.beat_number;
                have_first_next  = 1'b1;
            end
            last_beat_next = in_reg.local_time_ms;
        end
    end

    // result assembly
    always_comb begin
        res.offset_ms           = offset_next;
        res.converged           = conv_next;
        res.snapped             = upd.snap;
        res.duplicate           = dup;
        res.performer_restart   = upd.snap;
        res.pending_valid       = pend_next;
        res.pending_beat_number = pend_bn_next;
        res.pending_play_ms     = pend_play_next;
        res.pending_queued_ms   = pend_queued_next;
        res.last_beat_local_ms  = last_beat_next;
    end

    // state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg      <= '0;
            count_reg       <= '0;
            conv_reg        <= 1'b0;
            have_first_reg  <= 1'b0;
            last_bn_reg     <= '0;
            pend_reg        <= 1'b0;
            pend_bn_reg     <= '0;
            pend_play_reg   <= '0;
            pend_queued_reg <= '0;
            last_beat_reg   <= '0;
        end else if (advance) begin
            offset_reg      <= offset_next;
            count_reg       <= count_next;
            conv_reg        <= conv_next;
            have_first_reg  <= have_first_next;
            last_bn_reg     <= last_bn_next;
            pend_reg        <= pend_next;
            pend_bn_reg     <= pend_bn_next;
            pend_play_reg   <= pend_play_next;
            pend_queued_reg <= pend_queued_next;
            last_beat_reg   <= last_beat_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= res;
        end
    end

    // checks
    `COTBD_ASSERT_NOW(a_snap_not_dup, aclk, aresetn, advance && upd.snap, !dup)
    `COTBD_ASSERT_NOW(a_dup_has_pending, aclk, aresetn, advance && dup, pend_reg)
    `COTBD_ASSERT_NEXT(a_count_nonzero, aclk, aresetn, advance, count_reg != 16'd0)
    `COTBD_ASSERT_NEXT(a_result_loaded, aclk, aresetn, advance, out_vld_reg)

endmodule
